// File: sv/tab_expander_with_scroll_window_defines.svh
// Assertion macros for the tab expander with scroll window.
// Used by the top level; expects clk and rst_n in scope where expanded.
`ifndef TAB_EXPANDER_WITH_SCROLL_WINDOW_DEFINES_SVH
`define TAB_EXPANDER_WITH_SCROLL_WINDOW_DEFINES_SVH
`ifndef SYNTH
`define TWE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TWE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TWE_ASSERT_IMP(lbl, ante, cons, msg)
`define TWE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/twe_pkg.sv
// Shared types and constants of the tab expander with scroll window.
// No dependencies; imported by every module of the block.
package twe_pkg;

    localparam int unsigned CODE_W    = 21;
    localparam int unsigned COL_W     = 13;
    localparam int unsigned SCOL_W    = 12;
    localparam int unsigned TW_W      = 7;
    localparam int unsigned REM_W     = 7;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned DIV_STEPS = COL_W;
    localparam int unsigned DIV_CNT_W = 4;

    localparam logic [CODE_W-1:0] TAB_CODE   = 21'd9;
    localparam logic [CODE_W-1:0] SPACE_CODE = 21'd32;
    localparam logic [TW_W-1:0]   MAX_TAB    = 7'd64;
    localparam logic [COL_W-1:0]  MAX_COLS   = 13'd4096;

    localparam logic [1:0] REG_TAB_WIDTH    = 2'd0;
    localparam logic [1:0] REG_TAB_ALIGN    = 2'd1;
    localparam logic [1:0] REG_HORIZ_POS    = 2'd2;
    localparam logic [1:0] REG_VISIBLE_COLS = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        logic              line_last;
    } req_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] out_code;
        logic [SCOL_W-1:0] screen_col;
        logic              run_last;
    } res_item_t;

    typedef struct packed {
        logic [TW_W-1:0]   tab_width;
        logic              tab_align;
        logic [SCOL_W-1:0] horiz_pos;
        logic [COL_W-1:0]  visible_cols;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic setup;
        logic emit;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic req_tab_aligned;
        logic div_done;
        logic run_empty;
        logic slot_free;
        logic emit_end;
    } dp_status_t;

endpackage

// File: sv/twe_regs.sv
// Configuration register file behind the APB-style port.
// Depends on twe_pkg.
module twe_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [twe_pkg::ADDR_W-1:0]  paddr,
    input  logic [twe_pkg::DATA_W-1:0]  pwdata,
    output logic [twe_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output twe_pkg::cfg_t               cfg
);
    import twe_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_TAB_WIDTH:    cfg_next.tab_width    = pwdata[TW_W-1:0];
                REG_TAB_ALIGN:    cfg_next.tab_align    = pwdata[0];
                REG_HORIZ_POS:    cfg_next.horiz_pos    = pwdata[SCOL_W-1:0];
                REG_VISIBLE_COLS: cfg_next.visible_cols = pwdata[COL_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TAB_WIDTH:    prdata = DATA_W'(cfg_reg.tab_width);
            REG_TAB_ALIGN:    prdata = DATA_W'(cfg_reg.tab_align);
            REG_HORIZ_POS:    prdata = DATA_W'(cfg_reg.horiz_pos);
            REG_VISIBLE_COLS: prdata = DATA_W'(cfg_reg.visible_cols);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tab_width    <= 7'd8;
            cfg_reg.tab_align    <= 1'b1;
            cfg_reg.horiz_pos    <= '0;
            cfg_reg.visible_cols <= 13'd80;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: sv/twe_ctrl.sv
// Controller state machine: sequences load, remainder division, setup,
// emission and the finish step. Depends on twe_pkg.
module twe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  twe_pkg::dp_status_t status,
    output twe_pkg::dp_cmd_t    cmd
);
    import twe_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.req_tab_aligned ? S_DIV : S_SETUP;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = status.run_empty ? S_FINISH : S_EMIT;
            end
            S_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_end)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/twe_dp.sv
// Datapath: column count, bit-serial remainder unit, run bounds and the
// result register. Depends on twe_pkg.
module twe_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  twe_pkg::cfg_t        cfg,
    input  twe_pkg::req_item_t   req_item,
    input  twe_pkg::dp_cmd_t     cmd,
    output twe_pkg::dp_status_t  status,
    output logic                 res_valid,
    input  logic                 res_ready,
    output twe_pkg::res_item_t   res_item
);
    import twe_pkg::*;

    logic [COL_W-1:0]     column_reg, column_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic                 last_reg, last_next;
    logic                 tab_reg, tab_next;
    logic [COL_W-1:0]     quo_reg, quo_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [COL_W-1:0]     cur_reg, cur_next;
    logic [COL_W-1:0]     stop_reg, stop_next;
    logic                 res_valid_reg, res_valid_next;
    res_item_t            res_item_reg, res_item_next;

    logic [TW_W-1:0]   tw_sat;
    logic [COL_W-1:0]  vc_sat;
    logic [COL_W-1:0]  hp_col;
    logic [COL_W-1:0]  right;
    logic [REM_W-1:0]  trial;
    logic [TW_W-1:0]   adv;
    logic [COL_W:0]    stop_raw;
    logic [COL_W-1:0]  stop_clip;
    logic [COL_W-1:0]  first_col;
    logic              in_window;
    logic [COL_W-1:0]  cur_inc;

    always_comb
    begin
        if (cfg.tab_width == '0)
        begin
            tw_sat = TW_W'(1);
        end
        else if (cfg.tab_width > MAX_TAB)
        begin
            tw_sat = MAX_TAB;
        end
        else
        begin
            tw_sat = cfg.tab_width;
        end
    end

    assign vc_sat = (cfg.visible_cols > MAX_COLS) ? MAX_COLS : cfg.visible_cols;
    assign hp_col = COL_W'(cfg.horiz_pos);
    assign right  = hp_col + vc_sat;

    // One restoring step per cycle; the remainder stays below tw_sat.
    assign trial = {rem_reg[REM_W-2:0], quo_reg[COL_W-1]};

    // An aligned tab ends at the next stop: column minus remainder plus width.
    always_comb
    begin
        if (!tab_reg)
        begin
            adv = TW_W'(1);
        end
        else if (cfg.tab_align)
        begin
            adv = tw_sat - TW_W'(rem_reg);
        end
        else
        begin
            adv = tw_sat;
        end
    end

    assign stop_raw  = {1'b0, column_reg} + (COL_W+1)'(adv);
    assign stop_clip = (stop_raw > {1'b0, right}) ? right : stop_raw[COL_W-1:0];
    assign in_window = column_reg < right;
    assign first_col = (column_reg > hp_col) ? column_reg : hp_col;
    assign cur_inc   = cur_reg + COL_W'(1);

    assign status.req_tab_aligned = (req_item.code_point == TAB_CODE) && cfg.tab_align;
    assign status.div_done        = cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign status.run_empty       = !in_window || (first_col >= stop_clip);
    assign status.slot_free       = !res_valid_reg || res_ready;
    assign status.emit_end        = cur_inc == stop_reg;

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    always_comb
    begin
        column_next    = column_reg;
        code_next      = code_reg;
        last_next      = last_reg;
        tab_next       = tab_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        stop_next      = stop_reg;
        res_valid_next = res_valid_reg;
        res_item_next  = res_item_reg;

        if (res_ready)
        begin
            res_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            code_next = req_item.code_point;
            last_next = req_item.line_last;
            tab_next  = req_item.code_point == TAB_CODE;
            quo_next  = column_reg;
            rem_next  = '0;
            cnt_next  = '0;
        end

        if (cmd.div_step)
        begin
            quo_next = quo_reg << 1;
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (trial >= REM_W'(tw_sat))
            begin
                rem_next = trial - REM_W'(tw_sat);
            end
            else
            begin
                rem_next = trial;
            end
        end

        // Past the right edge the count is left as it is.
        if (cmd.setup && in_window)
        begin
            column_next = stop_clip;
            cur_next    = first_col;
            stop_next   = stop_clip;
        end

        if (cmd.emit)
        begin
            res_valid_next         = 1'b1;
            res_item_next.out_code = tab_reg ? SPACE_CODE : code_reg;
            res_item_next.screen_col = SCOL_W'(cur_reg - hp_col);
            res_item_next.run_last = cur_inc == stop_reg;
            cur_next               = cur_inc;
        end

        if (cmd.finish && last_reg)
        begin
            column_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            column_reg    <= column_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        last_reg     <= last_next;
        tab_reg      <= tab_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        cur_reg      <= cur_next;
        stop_reg     <= stop_next;
        res_item_reg <= res_item_next;
    end

endmodule

// File: sv/tab_expander_with_scroll_window.sv
// Tab expander with scroll window: one code point per request, one result per visible column.
// A request is loaded; an aligned tab then takes the bit-serial remainder of the column count
// by the tab width; setup sets the run bounds; each visible column is then emitted into the
// result register whenever it is free, and a finish step ends the request.
// A new request is taken while the last result of the previous one still waits.
// Reset (rst_n low, asynchronous) clears column count, controller and res_valid, presets config.
`include "tab_expander_with_scroll_window_defines.svh"

module tab_expander_with_scroll_window (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  twe_pkg::req_item_t          req_item,
    output logic                        res_valid,
    input  logic                        res_ready,
    output twe_pkg::res_item_t          res_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [twe_pkg::ADDR_W-1:0]  paddr,
    input  logic [twe_pkg::DATA_W-1:0]  pwdata,
    output logic [twe_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import twe_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    twe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    twe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    twe_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_item  (req_item),
        .cmd       (cmd),
        .status    (status),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    `TWE_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while busy")
    `TWE_ASSERT_IMP(a_no_overwrite, cmd.emit, !res_valid || res_ready, "pending result overwritten")
    `TWE_ASSERT_IMP(a_idle_no_emit, req_ready, !cmd.emit && !cmd.div_step, "work while idle")

endmodule

// File: sim/tab_expander_with_scroll_window_test.sv
`timescale 1ns / 100ps
// Self-checking bench for tab_expander_with_scroll_window: streams text lines with tabs
// through the request port, predicts every visible column and checks the result stream.
// Depends on twe_pkg and the RTL of the block.
module tab_expander_with_scroll_window_test;
    import twe_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_IDLE       = 12;
    localparam int TAB_CAP        = 64;
    localparam int COL_CAP        = 4096;
    localparam int RANDOM_ITEMS   = 325;
    localparam int unsigned CODE_MAX = 32'h1FFFFF;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    req_item_t         req_item  = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    res_item_t         res_item;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    req_item_t line_text[$];
    res_item_t expected_columns[$];
    cfg_t      shadow_cfg;
    int        line_column   = 0;
    bit        calm          = 1'b0;
    int        send_wait     = 0;
    int        recv_wait     = 0;
    int        idle_cycles   = 0;
    int        req_count     = 0;
    int        res_count     = 0;
    int        error_count   = 0;
    int        setting_count = 0;
    int        queued_items  = 0;

    tab_expander_with_scroll_window dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int idle_draw();
        return calm ? 0 : int'($urandom_range(0, MAX_IDLE));
    endfunction

    // Advances the line's column for one code point and queues every column that
    // lands inside the window.
    function automatic void expand_code_point(input req_item_t rq);
        int        tw;
        int        vc;
        int        right;
        int        stop;
        int        c;
        res_item_t col;
        tw = int'(shadow_cfg.tab_width);
        if (tw < 1) tw = 1;
        if (tw > TAB_CAP) tw = TAB_CAP;
        vc = int'(shadow_cfg.visible_cols);
        if (vc > COL_CAP) vc = COL_CAP;
        right = int'(shadow_cfg.horiz_pos) + vc;
        if (line_column < right)
        begin
            if (rq.code_point == TAB_CODE)
            begin
                stop = shadow_cfg.tab_align ? (line_column / tw + 1) * tw : line_column + tw;
                col.out_code = SPACE_CODE;
            end
            else
            begin
                stop = line_column + 1;
                col.out_code = rq.code_point;
            end
            if (stop > right) stop = right;
            for (c = line_column; c < stop; c++)
            begin
                if (c >= int'(shadow_cfg.horiz_pos))
                begin
                    col.screen_col = SCOL_W'(c - int'(shadow_cfg.horiz_pos));
                    col.run_last   = (c == stop - 1);
                    expected_columns.push_back(col);
                end
            end
            line_column = stop;
        end
        if (rq.line_last) line_column = 0;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_item  <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expand_code_point(req_item);
                req_count++;
            end
            if (!req_valid || req_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait <= send_wait - 1;
                    req_valid <= 1'b0;
                end
                else if (line_text.size() > 0)
                begin
                    req_item  <= line_text.pop_front();
                    req_valid <= 1'b1;
                    send_wait <= idle_draw();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin : result_check
        res_item_t want;
        int        stall;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            recv_wait <= 0;
        end
        else if (res_valid && res_ready)
        begin
            res_count++;
            if (expected_columns.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual code %0h col %0d last %b",
                         $time, res_item.out_code, res_item.screen_col, res_item.run_last);
            end
            else
            begin
                want = expected_columns.pop_front();
                compare_field("out_code", 32'(want.out_code), 32'(res_item.out_code));
                compare_field("screen_col", 32'(want.screen_col), 32'(res_item.screen_col));
                compare_field("run_last", 32'(want.run_last), 32'(res_item.run_last));
            end
            stall = idle_draw();
            recv_wait <= stall;
            res_ready <= (stall == 0);
        end
        else if (recv_wait > 0)
        begin
            recv_wait <= recv_wait - 1;
            res_ready <= (recv_wait == 1);
        end
        else
        begin
            res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (res_valid && res_ready) || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** tab_expander_with_scroll_window: FAILED **");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TAB_WIDTH:    shadow_cfg.tab_width    = value[TW_W-1:0];
            REG_TAB_ALIGN:    shadow_cfg.tab_align    = value[0];
            REG_HORIZ_POS:    shadow_cfg.horiz_pos    = value[SCOL_W-1:0];
            REG_VISIBLE_COLS: shadow_cfg.visible_cols = value[COL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int unsigned tw, input int unsigned align,
                                 input int unsigned horiz, input int unsigned vc);
        write_reg(REG_TAB_WIDTH, tw);
        write_reg(REG_TAB_ALIGN, align);
        write_reg(REG_HORIZ_POS, horiz);
        write_reg(REG_VISIBLE_COLS, vc);
        setting_count++;
    endtask

    // Holds the sender until every queued request is taken and every column has
    // come back, then leaves room for a request that produced no columns.
    task automatic drain_results();
        do @(negedge clk);
        while (line_text.size() != 0 || req_valid || expected_columns.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic put(input int unsigned code, input bit last);
        req_item_t rq;
        rq.code_point = code[CODE_W-1:0];
        rq.line_last  = last;
        line_text.push_back(rq);
        queued_items++;
    endtask

    function automatic int unsigned random_code(input bit tab_heavy);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < (tab_heavy ? 80 : 30)) return 32'(TAB_CODE);
        if (r < 88) return $urandom_range(32, 126);
        return $urandom_range(0, CODE_MAX);
    endfunction

    // A line is mostly well formed; now and then line_last is flipped so lines
    // get cut short or run together.
    task automatic random_line(input bit tab_heavy);
        int len;
        int i;
        bit last;
        len = $urandom_range(1, tab_heavy ? 80 : 40);
        for (i = 0; i < len; i++)
        begin
            last = (i == len - 1);
            if ($urandom_range(0, 19) == 0) last = ~last;
            put(random_code(tab_heavy), last);
        end
    endtask

    initial
    begin : stimulus
        int          phase;
        int          target;
        int          phase_start;
        int unsigned r;
        int unsigned tw;
        int unsigned horiz;
        int unsigned vc;
        bit          far_window;
        shadow_cfg.tab_width    = 7'd8;
        shadow_cfg.tab_align    = 1'b1;
        shadow_cfg.horiz_pos    = '0;
        shadow_cfg.visible_cols = 13'd80;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register defaults: aligned tabs, extreme code points, line restart.
        put(32'h61, 1'b0);
        put(32'(TAB_CODE), 1'b0);
        put(0, 1'b0);
        put(CODE_MAX, 1'b0);
        put(32'h10FFFF, 1'b0);
        put(32'(TAB_CODE), 1'b0);
        put(32'h78, 1'b1);
        put(32'(TAB_CODE), 1'b0);
        put(32'(TAB_CODE), 1'b1);
        drain_results();

        // Narrow window [5,10) with fixed-width tabs: a tab across the left edge,
        // a tab across the right edge, then a full window ignoring the rest.
        apply_setting(4, 0, 5, 5);
        put(32'h61, 1'b0);
        put(32'h62, 1'b0);
        put(32'(TAB_CODE), 1'b0);
        put(32'h63, 1'b0);
        put(32'(TAB_CODE), 1'b0);
        put(32'h64, 1'b0);
        put(32'(TAB_CODE), 1'b0);
        put(32'h65, 1'b1);
        put(32'(TAB_CODE), 1'b1);
        drain_results();

        // Zero tab width acts as one; oversized window is clipped.
        apply_setting(0, 1, 0, 8191);
        put(32'(TAB_CODE), 1'b0);
        put(32'h7A, 1'b0);
        put(32'(TAB_CODE), 1'b1);
        drain_results();

        // Empty window: nothing comes out.
        apply_setting(127, 1, 4095, 0);
        put(32'h71, 1'b0);
        put(32'(TAB_CODE), 1'b1);
        drain_results();

        // Oversized tab width saturates: one tab fills 64 columns.
        apply_setting(100, 1, 0, 4096);
        put(32'(TAB_CODE), 1'b0);
        put(32'h6D, 1'b1);
        drain_results();

        phase = 0;
        phase_start = queued_items;
        while (queued_items - phase_start < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 10) tw = 0;
            else if (r < 20) tw = $urandom_range(17, 127);
            else if (r < 30) tw = 64;
            else tw = $urandom_range(1, 16);
            far_window = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (far_window)
            begin
                tw = 64;
                horiz = $urandom_range(2048, 4095);
            end
            else if (r < 75) horiz = $urandom_range(0, 30);
            else horiz = $urandom_range(31, 300);
            r = $urandom_range(0, 99);
            if (r < 8) vc = 0;
            else if (r < 16) vc = $urandom_range(4097, 8191);
            else if (r < 22) vc = 4096;
            else if (r < 60) vc = $urandom_range(1, 16);
            else vc = $urandom_range(17, 120);
            apply_setting(tw, $urandom_range(0, 1), horiz, vc);
            calm = ($urandom_range(0, 3) == 0);
            target = queued_items + $urandom_range(20, 45);
            while (queued_items < target)
            begin
                random_line(far_window);
                // Once, stop feeding mid-phase until the block has caught up.
                if (phase == 2 && queued_items >= target - 15 && queued_items < target)
                begin
                    drain_results();
                    phase++;
                end
            end
            drain_results();
            phase++;
        end

        $display("Covered %0d requests and %0d column results under %0d register settings,",
                 req_count, res_count, setting_count + 1);
        $display("including clipped windows, saturated widths and lines split by line_last.");
        if (error_count == 0)
        begin
            $display("** tab_expander_with_scroll_window: PASSED **");
        end
        else
        begin
            $display("** tab_expander_with_scroll_window: FAILED **");
        end
        $finish;
    end

endmodule
